[sv/scfp_pkg.sv]
// ============================================================================
// scfp_pkg: shared types and constants of the servo command frame parser.
// Frame bytes, parser phases, status codes and the frame event record.
// ============================================================================
package scfp_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 49;

    localparam logic [7:0] SYNC_A        = 8'hAA;
    localparam logic [7:0] SYNC_B        = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
    localparam logic [7:0] SERVO_FUNC_RST = 8'h66;
    localparam logic [15:0] MIN_PULSE_RST = 16'd600;
    localparam logic [15:0] MAX_PULSE_RST = 16'd2400;
    localparam logic [15:0] WIDTH_RST     = 16'd1500;

    localparam int unsigned HEAD_DEPTH = 4;

    typedef enum logic [1:0] {
        CFG_MIN_PULSE  = 2'd0,
        CFG_MAX_PULSE  = 2'd1,
        CFG_SERVO_FUNC = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_FUNC = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CSUM = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_APPLIED  = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_IGNORED  = 2'd2
    } t_frame_status;

    typedef struct packed {
        logic          valid;
        t_frame_status status;
        logic [7:0]    func;
        logic [15:0]   width_a;
        logic [15:0]   width_b;
        logic          indicator;
    } t_frame_evt;

endpackage

[sv/scfp_parser.sv]
// ============================================================================
// scfp_parser: frame state machine over accepted bytes.
// Keeps the running checksum, the payload head and the kept servo widths, and
// reports a frame event on each checksum byte.
// ============================================================================
module scfp_parser #(
    parameter int unsigned MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_servo_func_code,
    output scfp_pkg::t_frame_evt  o_evt
);

    localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [8:0] LenLimit = 9'(MAX_PAYLOAD);

    scfp_pkg::t_phase r_phase, n_phase;
    logic [CntW-1:0]  r_remaining, n_remaining;
    logic [2:0]       r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_head [scfp_pkg::HEAD_DEPTH];
    logic [7:0]       n_head [scfp_pkg::HEAD_DEPTH];
    logic [15:0]      r_width_a, n_width_a;
    logic [15:0]      r_width_b, n_width_b;
    logic             r_indicator, n_indicator;
    logic [7:0]       sum_plus;

    assign sum_plus = r_sum + i_rx_byte;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_count     = r_count;
        n_sum       = r_sum;
        n_func      = r_func;
        n_head      = r_head;
        n_width_a   = r_width_a;
        n_width_b   = r_width_b;
        n_indicator = r_indicator;
        o_evt       = '0;
        o_evt.status = scfp_pkg::ST_IGNORED;

        unique case (r_phase)
            scfp_pkg::PH_IDLE: begin
                if (i_rx_byte == scfp_pkg::SYNC_A) begin
                    n_phase = scfp_pkg::PH_SYNC;
                    n_sum   = i_rx_byte;
                end
            end
            scfp_pkg::PH_SYNC: begin
                if (i_rx_byte == scfp_pkg::SYNC_B) begin
                    n_phase = scfp_pkg::PH_FUNC;
                    n_sum   = sum_plus;
                end else begin
                    n_phase = scfp_pkg::PH_IDLE;
                end
            end
            scfp_pkg::PH_FUNC: begin
                if (i_rx_byte != 8'd0 && i_rx_byte < scfp_pkg::FUNC_LIMIT) begin
                    n_phase = scfp_pkg::PH_LEN;
                    n_func  = i_rx_byte;
                    n_sum   = sum_plus;
                end else begin
                    n_phase = scfp_pkg::PH_IDLE;
                end
            end
            scfp_pkg::PH_LEN: begin
                if ({1'b0, i_rx_byte} <= LenLimit) begin
                    n_phase     = scfp_pkg::PH_DATA;
                    n_remaining = i_rx_byte[CntW-1:0];
                    n_count     = 3'd0;
                    n_sum       = sum_plus;
                end else begin
                    n_phase = scfp_pkg::PH_IDLE;
                end
            end
            scfp_pkg::PH_DATA: begin
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 1'b1;
                    if (!r_count[2]) begin
                        n_head[r_count[1:0]] = i_rx_byte;
                        n_count              = r_count + 3'd1;
                    end
                    n_sum = sum_plus;
                    if (r_remaining == CntW'(1)) begin
                        n_phase = scfp_pkg::PH_CSUM;
                    end
                end else begin
                    n_phase = scfp_pkg::PH_IDLE;
                end
            end
            scfp_pkg::PH_CSUM: begin
                n_phase = scfp_pkg::PH_IDLE;
                if (!r_count[2]) begin
                    n_head[r_count[1:0]] = i_rx_byte;
                end
                o_evt.valid = 1'b1;
                if (r_sum != i_rx_byte) begin
                    o_evt.status = scfp_pkg::ST_MISMATCH;
                end else if (r_func == i_servo_func_code) begin
                    o_evt.status = scfp_pkg::ST_APPLIED;
                    n_indicator  = ~r_indicator;
                    n_width_a    = {n_head[0], n_head[1]};
                    n_width_b    = {n_head[2], n_head[3]};
                end else begin
                    o_evt.status = scfp_pkg::ST_IGNORED;
                end
            end
            default: begin
                n_phase = scfp_pkg::PH_IDLE;
            end
        endcase

        o_evt.valid     = o_evt.valid & i_accept;
        o_evt.func      = r_func;
        o_evt.width_a   = n_width_a;
        o_evt.width_b   = n_width_b;
        o_evt.indicator = n_indicator;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= scfp_pkg::PH_IDLE;
            r_remaining <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_func      <= '0;
            for (int i = 0; i < scfp_pkg::HEAD_DEPTH; i++) begin
                r_head[i] <= '0;
            end
            r_width_a   <= scfp_pkg::WIDTH_RST;
            r_width_b   <= scfp_pkg::WIDTH_RST;
            r_indicator <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_func      <= n_func;
            r_head      <= n_head;
            r_width_a   <= n_width_a;
            r_width_b   <= n_width_b;
            r_indicator <= n_indicator;
        end
    end

endmodule

[sv/scfp_out_stage.sv]
// ============================================================================
// scfp_out_stage: result register of the parser.
// Clamps the kept widths to the configured limits and holds the result word
// until the receiver takes it.
// ============================================================================
module scfp_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scfp_pkg::t_frame_evt i_evt,
    input  logic [15:0]          i_min_pulse,
    input  logic [15:0]          i_max_pulse,
    input  logic                 i_out_stall,
    output logic                 o_full_stalled,
    output logic                 o_out_valid,
    output logic [1:0]           o_frame_status,
    output logic [7:0]           o_frame_func,
    output logic [15:0]          o_servo_a_width,
    output logic [15:0]          o_servo_b_width,
    output logic                 o_indicator_on
);

    // The kept widths are signed while the limits are unsigned.
    function automatic logic [15:0] clamp_width(
        input logic [15:0] kept,
        input logic [15:0] lo,
        input logic [15:0] hi
    );
        logic signed [16:0] x;
        logic signed [16:0] lo_s;
        logic signed [16:0] hi_s;
        x    = $signed({kept[15], kept});
        lo_s = $signed({1'b0, lo});
        hi_s = $signed({1'b0, hi});
        if (x < lo_s) begin
            return lo;
        end else if (x > hi_s) begin
            return hi;
        end
        return kept;
    endfunction

    logic        r_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_func;
    logic [15:0] r_width_a;
    logic [15:0] r_width_b;
    logic        r_indicator;

    assign o_full_stalled = r_valid & i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_evt.valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid) begin
            r_status    <= i_evt.status;
            r_func      <= i_evt.func;
            r_width_a   <= clamp_width(i_evt.width_a, i_min_pulse, i_max_pulse);
            r_width_b   <= clamp_width(i_evt.width_b, i_min_pulse, i_max_pulse);
            r_indicator <= i_evt.indicator;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_frame_status  = r_status;
    assign o_frame_func    = r_func;
    assign o_servo_a_width = r_width_a;
    assign o_servo_b_width = r_width_b;
    assign o_indicator_on  = r_indicator;

endmodule

[sv/servo_command_frame_parser_core.sv]
// ============================================================================
// servo_command_frame_parser_core: servo command frame parser.
// Parses sync, function, length, payload and checksum bytes and reports one
// status word per completed frame with the clamped servo widths.
// ============================================================================
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ---------------------------
//  rx       in         i_in_valid / o_in_stall     i_rx_byte
//  result   out        o_out_valid / i_out_stall   status, func, widths, ind.
//  config   in         i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// One byte is taken every cycle unless the input stalls; a checksum byte
// shows its word on the next cycle. Synchronous active-low reset returns the
// parser, the kept widths and the limits to their reset values. The input
// stalls only while the receiver stalls a word held in the output register.
// ============================================================================
module servo_command_frame_parser_core #(
    parameter int unsigned MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_func,
    output logic [15:0] o_servo_a_width,
    output logic [15:0] o_servo_b_width,
    output logic        o_indicator_on,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0] r_min_pulse;
    logic [15:0] r_max_pulse;
    logic [7:0]  r_servo_func;
    logic        accept;
    logic        full_stalled;
    scfp_pkg::t_frame_evt evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse  <= scfp_pkg::MIN_PULSE_RST;
            r_max_pulse  <= scfp_pkg::MAX_PULSE_RST;
            r_servo_func <= scfp_pkg::SERVO_FUNC_RST;
        end else if (i_cfg_wr_en) begin
            unique case (scfp_pkg::t_cfg_index'(i_cfg_index))
                scfp_pkg::CFG_MIN_PULSE:  r_min_pulse  <= i_cfg_wdata;
                scfp_pkg::CFG_MAX_PULSE:  r_max_pulse  <= i_cfg_wdata;
                scfp_pkg::CFG_SERVO_FUNC: r_servo_func <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = full_stalled;
    assign accept     = i_in_valid & ~full_stalled;

    scfp_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx_byte),
        .i_servo_func_code (r_servo_func),
        .o_evt             (evt)
    );

    scfp_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_evt           (evt),
        .i_min_pulse     (r_min_pulse),
        .i_max_pulse     (r_max_pulse),
        .i_out_stall     (i_out_stall),
        .o_full_stalled  (full_stalled),
        .o_out_valid     (o_out_valid),
        .o_frame_status  (o_frame_status),
        .o_frame_func    (o_frame_func),
        .o_servo_a_width (o_servo_a_width),
        .o_servo_b_width (o_servo_b_width),
        .o_indicator_on  (o_indicator_on)
    );

endmodule

[tb/servo_command_frame_parser_core_test.sv]
// ============================================================================
// servo_command_frame_parser_core_test: self-checking bench for the parser.
// A scoreboard class tracks the frame state machine byte by byte and keeps a
// queue of expected status words. The bench sends directed frames for the
// edge cases, then random frames, noise and cut-off frames under several
// clamp and function-code settings. Random gaps and stalls are applied on
// both channels, and one long receiver hold makes the input back up.
// ============================================================================
module servo_command_frame_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        scfp_pkg::t_frame_status status;
        logic [7:0]    func;
        logic [15:0]   width_a;
        logic [15:0]   width_b;
        logic          indicator;
    } t_servo_word;

    class frame_scoreboard;
        logic [15:0]   min_pulse;
        logic [15:0]   max_pulse;
        logic [7:0]    servo_code;
        scfp_pkg::t_phase phase;
        int unsigned   remaining;
        int unsigned   head_count;
        logic [7:0]    sum;
        logic [7:0]    func;
        logic [7:0]    head [scfp_pkg::HEAD_DEPTH];
        logic [15:0]   kept [2];
        logic          indicator;
        t_servo_word   expected_words [$];
        int            errors;
        int            n_bytes;
        int            n_words;
        int            status_count [3];

        function new();
            min_pulse  = scfp_pkg::MIN_PULSE_RST;
            max_pulse  = scfp_pkg::MAX_PULSE_RST;
            servo_code = scfp_pkg::SERVO_FUNC_RST;
            phase      = scfp_pkg::PH_IDLE;
            remaining  = 0;
            head_count = 0;
            sum        = '0;
            func       = '0;
            foreach (head[i]) head[i] = '0;
            kept[0]    = scfp_pkg::WIDTH_RST;
            kept[1]    = scfp_pkg::WIDTH_RST;
            indicator  = 1'b0;
            errors     = 0;
            n_bytes    = 0;
            n_words    = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void write_reg(scfp_pkg::t_cfg_index idx, logic [15:0] val);
            case (idx)
                scfp_pkg::CFG_MIN_PULSE:  min_pulse  = val;
                scfp_pkg::CFG_MAX_PULSE:  max_pulse  = val;
                scfp_pkg::CFG_SERVO_FUNC: servo_code = val[7:0];
                default: ;
            endcase
        endfunction

        // Kept widths are signed; the limits are unsigned and the low test wins.
        function logic [15:0] clamp_width(logic [15:0] width);
            int x;
            int lo;
            int hi;
            x  = int'($signed(width));
            lo = int'(min_pulse);
            hi = int'(max_pulse);
            if (x < lo)
                x = lo;
            else if (x > hi)
                x = hi;
            return x[15:0];
        endfunction

        function void note_byte(logic [7:0] b);
            t_servo_word w;
            bit taken;
            n_bytes++;
            taken = 1'b1;
            case (phase)
                scfp_pkg::PH_IDLE: begin
                    if (b == scfp_pkg::SYNC_A) begin
                        phase = scfp_pkg::PH_SYNC;
                        sum   = b;
                    end else begin
                        taken = 1'b0;
                    end
                end
                scfp_pkg::PH_SYNC: begin
                    if (b == scfp_pkg::SYNC_B) begin
                        phase = scfp_pkg::PH_FUNC;
                        sum   = sum + b;
                    end else begin
                        taken = 1'b0;
                    end
                end
                scfp_pkg::PH_FUNC: begin
                    if (b != 8'd0 && b < scfp_pkg::FUNC_LIMIT) begin
                        phase = scfp_pkg::PH_LEN;
                        func  = b;
                        sum   = sum + b;
                    end else begin
                        taken = 1'b0;
                    end
                end
                scfp_pkg::PH_LEN: begin
                    if (b <= scfp_pkg::MAX_PAYLOAD_DEF) begin
                        phase      = scfp_pkg::PH_DATA;
                        remaining  = 32'(b);
                        head_count = 0;
                        sum        = sum + b;
                    end else begin
                        taken = 1'b0;
                    end
                end
                scfp_pkg::PH_DATA: begin
                    if (remaining != 0) begin
                        remaining--;
                        if (head_count < scfp_pkg::HEAD_DEPTH)
                            head[head_count] = b;
                        head_count++;
                        sum = sum + b;
                        if (remaining == 0)
                            phase = scfp_pkg::PH_CSUM;
                    end else begin
                        taken = 1'b0;
                    end
                end
                scfp_pkg::PH_CSUM: begin
                    phase = scfp_pkg::PH_IDLE;
                    if (head_count < scfp_pkg::HEAD_DEPTH)
                        head[head_count] = b;
                    if (sum != b) begin
                        w.status = scfp_pkg::ST_MISMATCH;
                    end else if (func == servo_code) begin
                        w.status  = scfp_pkg::ST_APPLIED;
                        indicator = ~indicator;
                        kept[0]   = {head[0], head[1]};
                        kept[1]   = {head[2], head[3]};
                    end else begin
                        w.status = scfp_pkg::ST_IGNORED;
                    end
                    w.func      = func;
                    w.width_a   = clamp_width(kept[0]);
                    w.width_b   = clamp_width(kept[1]);
                    w.indicator = indicator;
                    expected_words.push_back(w);
                    status_count[w.status]++;
                end
                default: taken = 1'b0;
            endcase
            if (!taken)
                phase = scfp_pkg::PH_IDLE;
        endfunction

        function void check_word(logic [1:0] st, logic [7:0] fn, logic [15:0] a,
                                 logic [15:0] b, logic ind);
            t_servo_word w;
            n_words++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %0d: status %0d func %02h a %0d b %0d ind %0b",
                             n_words, st, fn, a, b, ind);
                return;
            end
            w = expected_words.pop_front();
            if (w.status != scfp_pkg::t_frame_status'(st) || w.func != fn ||
                w.width_a != a || w.width_b != b || w.indicator != ind) begin
                errors++;
                if (errors <= 10) begin
                    $display("word %0d mismatch: expected status %0d func %02h a %0d b %0d ind %0b",
                             n_words, w.status, w.func, w.width_a, w.width_b, w.indicator);
                    $display("                   got      status %0d func %02h a %0d b %0d ind %0b",
                             st, fn, a, b, ind);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_frame_func;
    logic [15:0] o_servo_a_width;
    logic [15:0] o_servo_b_width;
    logic        o_indicator_on;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    frame_scoreboard sb;
    bit calm;
    bit hold_request;
    int in_stall_cycles;

    servo_command_frame_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_status  (o_frame_status),
        .o_frame_func    (o_frame_func),
        .o_servo_a_width (o_servo_a_width),
        .o_servo_b_width (o_servo_b_width),
        .o_indicator_on  (o_indicator_on),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_byte(i_rx_byte);
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stall_cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_frame_status, o_frame_func, o_servo_a_width,
                          o_servo_b_width, o_indicator_on);
    end

    initial begin
        int hold_left;
        int seg_left;
        bit seg_stall;
        int r;
        hold_left   = 0;
        seg_left    = 0;
        seg_stall   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_stall = ($urandom_range(0, 99) < 35);
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        seg_left = $urandom_range(1, 3);
                    else if (r < 95)
                        seg_left = $urandom_range(4, 10);
                    else
                        seg_left = $urandom_range(20, 60);
                end
                seg_left--;
                i_out_stall <= seg_stall;
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout waiting for the parser");
        $display("servo_command_frame_parser_core_test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Called and returns at a falling edge; the byte is held until taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] fn, input logic [7:0] len,
                              input logic [31:0] head, input bit good_sum, input int cut);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        int n;
        bytes = {scfp_pkg::SYNC_A, scfp_pkg::SYNC_B, fn, len};
        n = (len <= scfp_pkg::MAX_PAYLOAD_DEF) ? len : 3;
        for (int i = 0; i < n; i++)
            bytes.push_back(i < 4 ? head[31 - 8 * i -: 8] : 8'($urandom));
        sum = '0;
        foreach (bytes[i]) sum = sum + bytes[i];
        bytes.push_back(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
        if (cut >= 0)
            while (bytes.size() > cut) void'(bytes.pop_back());
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    // Drains all expected words, then lets the pipeline settle.
    task automatic settle();
        int cycles;
        cycles = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && cycles < 2000) begin
            @(negedge i_clk);
            cycles++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input scfp_pkg::t_cfg_index idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [7:0] code);
        write_reg(scfp_pkg::CFG_MIN_PULSE, lo);
        write_reg(scfp_pkg::CFG_MAX_PULSE, hi);
        write_reg(scfp_pkg::CFG_SERVO_FUNC, {8'($urandom), code});
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_frames(input int n_target);
        int start;
        int r;
        int k;
        logic [7:0] fn;
        logic [7:0] len;
        start = sb.n_bytes;
        while (sb.n_bytes - start < n_target) begin
            if ($urandom_range(0, 19) == 0)
                calm = ~calm;
            r = $urandom_range(0, 99);
            fn = ($urandom_range(0, 2) != 0) ? sb.servo_code : 8'($urandom_range(1, 240));
            k = $urandom_range(0, 99);
            if (k < 80)
                len = 8'($urandom_range(0, 6));
            else if (k < 95)
                len = 8'($urandom_range(7, 20));
            else
                len = 8'($urandom_range(21, scfp_pkg::MAX_PAYLOAD_DEF));
            if (r < 75) begin
                send_frame(fn, len, $urandom, $urandom_range(0, 99) < 85, -1);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 5)) begin
                    k = $urandom_range(0, 3);
                    send_byte(k == 0 ? scfp_pkg::SYNC_A :
                              k == 1 ? scfp_pkg::SYNC_B : 8'($urandom));
                end
            end else begin
                send_frame(8'($urandom), 8'($urandom), $urandom, 1'b1,
                           $urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        sb           = new();
        calm         = 1'b0;
        hold_request = 1'b0;
        in_stall_cycles = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_rx_byte    = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = scfp_pkg::CFG_MIN_PULSE;
        i_cfg_wdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings.
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd4, {16'd1500, 16'd2000}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd4, {16'h8000, 16'h7FFF}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd5, {16'h0000, 16'hFFFF}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd4, {16'd700, 16'd800}, 1'b0, -1);
        send_frame(8'd1, 8'd4, {16'd900, 16'd1000}, 1'b1, -1);
        send_frame(8'd240, 8'd6, $urandom, 1'b1, -1);
        send_frame(8'd0, 8'd4, $urandom, 1'b1, -1);
        send_frame(scfp_pkg::FUNC_LIMIT, 8'd4, $urandom, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd0, $urandom, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd49, {16'd2000, 16'd1000}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd50, $urandom, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd1, {16'h0102, 16'h0304}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd2, {16'h0405, 16'h0607}, 1'b1, -1);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd3, {16'h0708, 16'h0900}, 1'b1, -1);
        send_byte(scfp_pkg::SYNC_A);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd4, {16'd1200, 16'd1300}, 1'b1, -1);
        send_byte(scfp_pkg::SYNC_A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(scfp_pkg::SERVO_FUNC_RST, 8'd4, {16'd1600, 16'd1700}, 1'b1, -1);
        settle();

        set_limits(16'd0, 16'hFFFF, 8'd1);
        random_frames(170);
        settle();

        set_limits(16'd3000, 16'd1000, 8'd240);
        hold_request = 1'b1;
        random_frames(170);
        settle();

        set_limits(16'hFFFF, 16'd0, 8'd0);
        random_frames(150);
        settle();

        set_limits(16'd1000, 16'd2000, 8'hFF);
        random_frames(150);
        settle();

        set_limits(16'($urandom_range(0, 1500)), 16'($urandom_range(1500, 3000)),
                   8'($urandom_range(1, 240)));
        random_frames(170);
        settle();

        set_limits(scfp_pkg::MIN_PULSE_RST, scfp_pkg::MAX_PULSE_RST,
                   scfp_pkg::SERVO_FUNC_RST);
        random_frames(100);
        settle();

        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0d expected words never arrived", sb.pending());
        end
        $display("sent %0d bytes, checked %0d words (applied %0d, bad checksum %0d, ignored %0d)",
                 sb.n_bytes, sb.n_words, sb.status_count[scfp_pkg::ST_APPLIED],
                 sb.status_count[scfp_pkg::ST_MISMATCH],
                 sb.status_count[scfp_pkg::ST_IGNORED]);
        $display("input held off for %0d cycles over seven limit settings; %0d errors",
                 in_stall_cycles, sb.errors);
        if (sb.errors == 0)
            $display("servo_command_frame_parser_core_test passed");
        else
            $display("servo_command_frame_parser_core_test failed");
        $finish;
    end

endmodule
